@@ src/cpes_pkg.sv @@
// ---------------------------------------------------------------------------
// Camera pan ease sequencer package
// Shared types and constants: sequencer states, pan phases, register map
// and the fixed widths of the rate and time fields.
// ---------------------------------------------------------------------------
package cpes_pkg;

  // Fixed field widths.
  localparam int DT_W      = 16;  // delta_time, unsigned Q0.16
  localparam int RATE_W    = 24;  // pan_rate and hold_rate, unsigned Q8.16
  localparam int RATE_FRAC = 32;  // fraction bits of rate * delta_time
  localparam int CFG_DW    = 32;  // configuration data width
  localparam int CFG_AW    = 5;   // configuration byte address width
  localparam int CFG_IW    = 3;   // register index width

  // Register map, index = byte address / 4.
  localparam logic [CFG_IW-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GOAL_X  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_GOAL_Y  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PAN     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HOLD    = 3'd5;

  // Reset value of both rates: 1.0 in Q8.16.
  localparam logic [RATE_W-1:0] RATE_RESET = 24'h010000;

  // Pan phases, as reported on the stage field.
  typedef enum logic [1:0] {
    PH_TO_TARGET = 2'd0,
    PH_HOLD      = 2'd1,
    PH_RETURN    = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  // Sequencer steps around the shared multiplier.
  typedef enum logic [3:0] {
    ST_IDLE,  // waiting for a request
    ST_INC,   // multiply rate by delta_time
    ST_ADV,   // advance and saturate progress
    ST_SQ,    // multiply t by t
    ST_CUBE,  // multiply t2 by (3 - 2t)
    ST_DX,    // latch s, form the x distance
    ST_MX,    // multiply x distance by s
    ST_RX,    // finish x, form the y distance
    ST_MY,    // multiply y distance by s
    ST_RY,    // finish y, phase transitions
    ST_FIN    // hand the result to the output register
  } seq_state_t;

endpackage

@@ src/camera_pan_ease_sequencer.sv @@
// ---------------------------------------------------------------------------
// Camera pan ease sequencer
// Steps a four-phase camera pan (to target, hold, return, done) once per
// tick request, with smoothstep easing computed on one shared multiplier.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Contents
//  --------+-----------+-----------------------+------------------------------------
//  in_     | slave     | tvalid/tready         | delta_time, follow_x, follow_y, restart
//  out_    | master    | tvalid/tready         | view_x, view_y, stage
//  cfg_    | APB slave | psel/penable/pready   | six pan registers at 4*index
//
// A moving-phase request steps from ST_INC through ST_RY, a hold request only
// through ST_INC and ST_ADV, and a done request goes straight to ST_FIN; every
// product goes through the single shared multiplier, one product per cycle.
// Reset (rst_n low, synchronous) clears phase, progress and the camera
// position and loads the register reset values.
// The output register holds one result; a stalled out_tready delays only the
// hand-off of the next result, and in_tready is low while a request is in work.
// ---------------------------------------------------------------------------
module camera_pan_ease_sequencer #(
  parameter int POS_WIDTH = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Tick requests: delta_time, follow_x, follow_y, restart (lowest bit up).
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((cpes_pkg::DT_W + 2*POS_WIDTH + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  // Results: view_x, view_y, stage (lowest bit up).
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((2*POS_WIDTH + 2 + 7) / 8) * 8 - 1:0] out_tdata,
  // Configuration port.
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [cpes_pkg::CFG_AW-1:0]           cfg_paddr,
  input  logic [cpes_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic [cpes_pkg::CFG_DW-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int P      = POS_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OUT_W  = ((2*P + 2 + 7) / 8) * 8;
  // Shared multiplier operand width: the widest of distance, 3 - 2t and rate.
  localparam int MW0    = (P + 1 > F + 2) ? P + 1 : F + 2;
  localparam int MW     = (MW0 > cpes_pkg::RATE_W) ? MW0 : cpes_pkg::RATE_W;
  localparam int PW     = 2 * MW;
  localparam int INC_SH = cpes_pkg::RATE_FRAC - F;
  localparam int INC_W  = cpes_pkg::RATE_W + cpes_pkg::DT_W - INC_SH;
  localparam int SUM_W  = INC_W + 1;
  localparam logic [F:0]       ONE_Q   = (F+1)'(1) << F;
  localparam logic [F+1:0]     THREE_Q = (F+2)'(3) << F;
  localparam logic [SUM_W-1:0] ONE_S   = SUM_W'(1) << F;
  localparam logic [PW:0]      RND_UP  = (PW+1)'(ONE_Q) - (PW+1)'(1);

  // Configuration registers.
  logic signed [P-1:0]             start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [cpes_pkg::RATE_W-1:0]     pan_rate_r, hold_rate_r;

  // Sequencer and pan state.
  cpes_pkg::seq_state_t            state_r, state_nxt;
  cpes_pkg::phase_t                phase_r;
  logic [F:0]                      progress_r;
  logic signed [P-1:0]             view_x_r, view_y_r;

  // Captured request fields.
  logic [cpes_pkg::DT_W-1:0]       dt_r;
  logic signed [P-1:0]             fol_x_r, fol_y_r;

  // Shared multiplier and its operands.
  logic [MW-1:0]                   mul_a, mul_b;
  logic [PW-1:0]                   prod_r;
  logic [F:0]                      s_r;
  logic [P:0]                      mag_r;
  logic                            neg_r;

  // Output register.
  logic                            out_valid_r;
  logic [OUT_W-1:0]                out_data_r;

  logic                            in_fire;
  logic                            cfg_wr;
  logic [cpes_pkg::CFG_IW-1:0]     cfg_idx;

  // Request field views.
  logic [cpes_pkg::DT_W-1:0]       in_dt;
  logic signed [P-1:0]             in_fx, in_fy;
  logic                            in_restart;

  // Arithmetic around the multiplier.
  logic [INC_W-1:0]                inc;
  logic [SUM_W-1:0]                sum;
  logic                            sat;
  logic signed [P-1:0]             a_x, b_x, a_y, b_y, a_cur, b_cur, a_res;
  logic signed [P:0]               dif;
  logic [P:0]                      mag;
  logic [PW:0]                     prod_up;
  logic [P:0]                      quo;
  logic signed [P:0]               blend_w;

  assign in_dt      = in_tdata[cpes_pkg::DT_W-1:0];
  assign in_fx      = in_tdata[cpes_pkg::DT_W +: P];
  assign in_fy      = in_tdata[cpes_pkg::DT_W + P +: P];
  assign in_restart = in_tdata[cpes_pkg::DT_W + 2*P];

  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes and reads.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[cpes_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      pan_rate_r  <= cpes_pkg::RATE_RESET;
      hold_rate_r <= cpes_pkg::RATE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cpes_pkg::REG_START_X: start_x_r   <= cfg_pwdata[P-1:0];
        cpes_pkg::REG_START_Y: start_y_r   <= cfg_pwdata[P-1:0];
        cpes_pkg::REG_GOAL_X:  goal_x_r    <= cfg_pwdata[P-1:0];
        cpes_pkg::REG_GOAL_Y:  goal_y_r    <= cfg_pwdata[P-1:0];
        cpes_pkg::REG_PAN:     pan_rate_r  <= cfg_pwdata[cpes_pkg::RATE_W-1:0];
        cpes_pkg::REG_HOLD:    hold_rate_r <= cfg_pwdata[cpes_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cpes_pkg::REG_START_X: cfg_prdata = cpes_pkg::CFG_DW'(start_x_r);
      cpes_pkg::REG_START_Y: cfg_prdata = cpes_pkg::CFG_DW'(start_y_r);
      cpes_pkg::REG_GOAL_X:  cfg_prdata = cpes_pkg::CFG_DW'(goal_x_r);
      cpes_pkg::REG_GOAL_Y:  cfg_prdata = cpes_pkg::CFG_DW'(goal_y_r);
      cpes_pkg::REG_PAN:     cfg_prdata = cpes_pkg::CFG_DW'(pan_rate_r);
      cpes_pkg::REG_HOLD:    cfg_prdata = cpes_pkg::CFG_DW'(hold_rate_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpes_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_restart || phase_r != cpes_pkg::PH_DONE) begin
            state_nxt = cpes_pkg::ST_INC;
          end else begin
            state_nxt = cpes_pkg::ST_FIN;
          end
        end
      end
      cpes_pkg::ST_INC:  state_nxt = cpes_pkg::ST_ADV;
      cpes_pkg::ST_ADV: begin
        if (phase_r == cpes_pkg::PH_HOLD) begin
          state_nxt = cpes_pkg::ST_FIN;
        end else begin
          state_nxt = cpes_pkg::ST_SQ;
        end
      end
      cpes_pkg::ST_SQ:   state_nxt = cpes_pkg::ST_CUBE;
      cpes_pkg::ST_CUBE: state_nxt = cpes_pkg::ST_DX;
      cpes_pkg::ST_DX:   state_nxt = cpes_pkg::ST_MX;
      cpes_pkg::ST_MX:   state_nxt = cpes_pkg::ST_RX;
      cpes_pkg::ST_RX:   state_nxt = cpes_pkg::ST_MY;
      cpes_pkg::ST_MY:   state_nxt = cpes_pkg::ST_RY;
      cpes_pkg::ST_RY:   state_nxt = cpes_pkg::ST_FIN;
      cpes_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = cpes_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = cpes_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: request ready and multiplier operand selection.
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      cpes_pkg::ST_IDLE: in_tready = 1'b1;
      cpes_pkg::ST_INC: begin
        mul_a = (phase_r == cpes_pkg::PH_HOLD) ? MW'(hold_rate_r) : MW'(pan_rate_r);
        mul_b = MW'(dt_r);
      end
      cpes_pkg::ST_SQ: begin
        mul_a = MW'(progress_r);
        mul_b = MW'(progress_r);
      end
      cpes_pkg::ST_CUBE: begin
        mul_a = MW'(prod_r[2*F:F]);
        mul_b = MW'(THREE_Q - {progress_r, 1'b0});
      end
      cpes_pkg::ST_MX, cpes_pkg::ST_MY: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(s_r);
      end
      default: ;
    endcase
  end

  // Progress advance with saturation at one.
  assign inc = prod_r[INC_SH +: INC_W];
  assign sum = SUM_W'(progress_r) + inc;
  assign sat = (sum >= ONE_S);

  // Blend endpoints: start to goal while moving out, goal to follow on return.
  always_comb begin
    if (phase_r == cpes_pkg::PH_RETURN) begin
      a_x = goal_x_r;
      b_x = fol_x_r;
      a_y = goal_y_r;
      b_y = fol_y_r;
    end else begin
      a_x = start_x_r;
      b_x = goal_x_r;
      a_y = start_y_r;
      b_y = goal_y_r;
    end
  end

  // Distance of the axis being set up: x in ST_DX, y in ST_RX.
  assign a_cur = (state_r == cpes_pkg::ST_DX) ? a_x : a_y;
  assign b_cur = (state_r == cpes_pkg::ST_DX) ? b_x : b_y;
  assign dif   = (P+1)'(b_cur) - (P+1)'(a_cur);
  assign mag   = dif[P] ? unsigned'(-dif) : unsigned'(dif);

  // Scaled distance, floored for a rising axis and ceiled for a falling one,
  // so that the sum rounds toward minus infinity either way.
  assign a_res   = (state_r == cpes_pkg::ST_RX) ? a_x : a_y;
  assign prod_up = (PW+1)'(prod_r) + RND_UP;
  assign quo     = neg_r ? prod_up[F +: P+1] : prod_r[F +: P+1];
  assign blend_w = neg_r ? (P+1)'(a_res) - signed'(quo) : (P+1)'(a_res) + signed'(quo);

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath and pan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cpes_pkg::ST_IDLE;
      phase_r    <= cpes_pkg::PH_TO_TARGET;
      progress_r <= '0;
      view_x_r   <= '0;
      view_y_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        cpes_pkg::ST_IDLE: begin
          if (in_fire && in_restart) begin
            phase_r    <= cpes_pkg::PH_TO_TARGET;
            progress_r <= '0;
          end
        end
        cpes_pkg::ST_ADV: begin
          if (phase_r == cpes_pkg::PH_HOLD) begin
            if (sat) begin
              progress_r <= '0;
              phase_r    <= cpes_pkg::PH_RETURN;
            end else begin
              progress_r <= sum[F:0];
            end
          end else begin
            progress_r <= sat ? ONE_Q : sum[F:0];
          end
        end
        cpes_pkg::ST_RX: view_x_r <= blend_w[P-1:0];
        cpes_pkg::ST_RY: begin
          if (progress_r >= ONE_Q && phase_r == cpes_pkg::PH_TO_TARGET) begin
            // End of the outbound pan: snap to the goal and start the hold.
            view_x_r   <= goal_x_r;
            view_y_r   <= goal_y_r;
            progress_r <= '0;
            phase_r    <= cpes_pkg::PH_HOLD;
          end else begin
            view_y_r <= blend_w[P-1:0];
            if (progress_r >= ONE_Q) begin
              phase_r <= cpes_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture, eased value and distance magnitude.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dt_r    <= in_dt;
      fol_x_r <= in_fx;
      fol_y_r <= in_fy;
    end
    if (state_r == cpes_pkg::ST_DX) begin
      s_r <= prod_r[2*F:F];
    end
    if (state_r == cpes_pkg::ST_DX || state_r == cpes_pkg::ST_RX) begin
      mag_r <= mag;
      neg_r <= dif[P];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == cpes_pkg::ST_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cpes_pkg::ST_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= OUT_W'({phase_r, view_y_r, view_x_r});
    end
  end

endmodule
